@@ rtl/ctm_pkg.sv @@
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared types and constants of the cadenced tone mixer.
// ----------------------------------------------------------------------------
package ctm_pkg;

	localparam int MAX_PHASES = 4;

	localparam logic [2:0] REG_AMP    = 3'd0;
	localparam logic [2:0] REG_STEPS  = 3'd1;
	localparam logic [2:0] REG_TONE   = 3'd2;
	localparam logic [2:0] REG_CAD    = 3'd3;
	localparam logic [2:0] REG_ACTIVE = 3'd4;
	localparam logic [2:0] REG_PAUSE  = 3'd5;
	localparam logic [2:0] REG_RATE   = 3'd6;
	localparam logic [2:0] REG_STEREO = 3'd7;

	localparam int NUM_W = 48;
	localparam int DEN_W = 32;
	localparam int QUO_W = 34;
	localparam int REM_W = 25;

	localparam logic [5:0] DIV_LONG_STEPS  = 6'd34;
	localparam logic [5:0] DIV_SHORT_STEPS = 6'd17;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [DEN_W-1:0] MS_PER_SEC = 32'd1000;
	localparam logic [17:0] RATE_RESET = 18'd8000;

	typedef struct packed {
		logic             start;
		logic             long_mode;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

@@ rtl/ctm_if.sv @@
// ----------------------------------------------------------------------------
// ctm_if
// Valid/ready channels for input frames and mixed result frames.
// ----------------------------------------------------------------------------
interface ctm_in_if;
	logic               valid;
	logic               ready;
	logic               buffer_start;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;

	modport source (output valid, buffer_start, left_sample, right_sample, input ready);
	modport sink (input valid, buffer_start, left_sample, right_sample, output ready);
endinterface

interface ctm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic               tone_on;

	modport source (output valid, left_out, right_out, tone_on, input ready);
	modport sink (input valid, left_out, right_out, tone_on, output ready);
endinterface

@@ rtl/cadenced_tone_mixer_core.sv @@
// ----------------------------------------------------------------------------
// cadenced_tone_mixer_core
// Mixes a cadenced one- or two-sine tone into 16-bit audio frames.
//
//   channel  dir  handshake     payload
//   din      in   valid/ready   buffer_start, left_sample, right_sample
//   dout     out  valid/ready   left_out, right_out, tone_on
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// One item at a time through a sequencer around one shared multiplier and one
// bit-serial divider. An item runs a sine step, an amplitude product, and then
// the numerator and division once per channel, after a tone product when two
// modulated tones sound; each cadence step or restart adds a duration product and division.
// din is ready only when idle; a stalled result holds dout and the block.
// Reset is asynchronous and needs no sweep.
// ----------------------------------------------------------------------------
module cadenced_tone_mixer_core #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int PHASE_BITS      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ctm_in_if.sink      din,
	ctm_out_if.source   dout,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import ctm_pkg::*;

	localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
	localparam int QW      = SINE_TABLE_BITS - 1;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LMUL   = 4'd1;
	localparam logic [3:0] ST_LSTART = 4'd2;
	localparam logic [3:0] ST_LDIV   = 4'd3;
	localparam logic [3:0] ST_SIN    = 4'd4;
	localparam logic [3:0] ST_TMUL   = 4'd5;
	localparam logic [3:0] ST_AMUL   = 4'd6;
	localparam logic [3:0] ST_NUM    = 4'd7;
	localparam logic [3:0] ST_DIV    = 4'd8;
	localparam logic [3:0] ST_UPD    = 4'd9;
	localparam logic [3:0] ST_FIN    = 4'd10;

	typedef logic [14:0] lut_t [0:QUARTER];

	function automatic lut_t build_lut();
		lut_t        t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] y;
		for (int q = 0; q <= QUARTER; q++) begin
			x    = (64'(q) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
			x2   = (x * x) >> 30;
			term = x;
			acc  = x;
			term = ((term * x2) >> 30) / 64'd6;
			acc  = acc - term;
			term = ((term * x2) >> 30) / 64'd20;
			acc  = acc + term;
			term = ((term * x2) >> 30) / 64'd42;
			acc  = acc - term;
			term = ((term * x2) >> 30) / 64'd72;
			acc  = acc + term;
			y    = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
			t[q] = (y > 64'd32767) ? 15'h7fff : y[14:0];
		end
		return t;
	endfunction

	localparam lut_t SINE_LUT = build_lut();

	function automatic logic signed [15:0] sine_of(input logic [PHASE_BITS-1:0] ph);
		logic [SINE_TABLE_BITS-1:0] idx;
		logic [QW-1:0]              q;
		logic [14:0]                m;
		idx = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
		q   = {1'b0, idx[SINE_TABLE_BITS-3:0]};
		if (idx[SINE_TABLE_BITS-2]) begin
			q = QW'(QUARTER) - q;
		end
		m = SINE_LUT[q];
		return idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	// configuration
	logic [14:0] amp_q;
	logic [63:0] steps_q;
	logic [2:0]  tone_setup_q;
	logic [3:0]  cad_q;
	logic [63:0] active_q;
	logic [63:0] pause_q;
	logic [17:0] rate_q;
	logic        stereo_q;

	// cadence and oscillator state
	logic [PHASE_BITS-1:0] phase_q [2];
	logic [1:0]            idx_q;
	logic                  in_tone_q;
	logic [REM_W-1:0]      remain_q;
	logic                  started_q;

	// sequencer and item registers
	logic [3:0]         state_q;
	logic               ld_pause_q;
	logic               ld_last_q;
	logic               chan_q;
	logic               neg_q;
	logic               tone_on_q;
	logic signed [15:0] inl_q;
	logic signed [15:0] inr_q;
	logic signed [15:0] s0_q;
	logic signed [15:0] s1_q;
	logic signed [31:0] tone_q;
	logic signed [47:0] mul_q;
	logic signed [15:0] lout_q;
	logic signed [15:0] rout_q;

	logic [1:0]         count;
	logic               modulate;
	logic               mod2;
	logic [2:0]         nph;
	logic [1:0]         loop_start;
	logic [1:0]         idx_next;
	logic [15:0]        ms;
	logic signed [15:0] s0;
	logic signed [15:0] s1;
	logic signed [31:0] tone_d;
	logic signed [32:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [51:0] prod;
	logic signed [47:0] in_x;
	logic signed [47:0] in_scaled;
	logic signed [47:0] num;
	logic [47:0]        num_mag;
	logic [15:0]        amp_p;
	logic [31:0]        den;
	logic [17:0]        qmag;
	logic signed [18:0] qval;
	logic signed [15:0] qsat;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign count    = (tone_setup_q[1:0] == 2'd3) ? 2'd2 : tone_setup_q[1:0];
	assign modulate = tone_setup_q[2];
	assign mod2     = modulate && (count == 2'd2) && in_tone_q;

	always_comb begin
		nph = {1'b0, cad_q[1:0]} + 3'd1;
		if ({1'b0, nph} > 4'(MAX_PHASES)) begin
			nph = 3'(MAX_PHASES);
		end
		loop_start = cad_q[3:2];
		if ({2'b0, loop_start} >= 4'(MAX_PHASES)) begin
			loop_start = 2'd0;
		end
		idx_next = ({1'b0, idx_q} + 3'd1 < nph) ? idx_q + 2'd1 : loop_start;
	end

	assign ms = ld_pause_q ? pause_q[16*idx_q +: 16] : active_q[16*idx_q +: 16];
	assign s0 = sine_of(phase_q[0]);
	assign s1 = sine_of(phase_q[1]);

	always_comb begin
		tone_d = '0;
		if (in_tone_q && count != 2'd0) begin
			if (modulate) begin
				tone_d = ({{16{s0[15]}}, s0} <<< 15) - {{16{s0[15]}}, s0};
			end else if (count == 2'd2) begin
				tone_d = {{16{s0[15]}}, s0} + {{16{s1[15]}}, s1};
			end else begin
				tone_d = {{16{s0[15]}}, s0};
			end
		end
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_LMUL: begin
				mul_a = {15'd0, rate_q};
				mul_b = {3'd0, ms};
			end
			ST_TMUL: begin
				mul_a = {{17{s0_q[15]}}, s0_q};
				mul_b = {{3{s1_q[15]}}, s1_q};
			end
			default: begin
				mul_a = mod2 ? {mul_q[31], mul_q[31:0]} : {tone_q[31], tone_q};
				mul_b = {4'd0, amp_q};
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// numerator and denominator of the mix
	assign in_x = chan_q ? 48'(inr_q) : 48'(inl_q);
	assign in_scaled = modulate ? (in_x <<< 30) - (in_x <<< 16) + in_x
		: (in_x <<< 15) - in_x;
	assign num     = mul_q + in_scaled;
	assign num_mag = num[47] ? 48'(-num) : 48'(num);
	assign amp_p   = {1'b0, amp_q} + 16'd32767;

	always_comb begin
		if (modulate) begin
			den = ({16'd0, amp_p} << 15) - {16'd0, amp_p};
		end else if (count == 2'd2) begin
			den = {16'd0, amp_q, 1'b0} + 32'd32767;
		end else if (count == 2'd1) begin
			den = {17'd0, amp_q} + 32'd32767;
		end else begin
			den = 32'd32767;
		end
	end

	always_comb begin
		div_req.start     = 1'b0;
		div_req.long_mode = 1'b0;
		div_req.num       = num_mag;
		div_req.den       = den;
		if (state_q == ST_LSTART) begin
			div_req.start     = 1'b1;
			div_req.long_mode = 1'b1;
			div_req.num       = {14'd0, mul_q[33:0]};
			div_req.den       = MS_PER_SEC;
		end else if (state_q == ST_NUM) begin
			div_req.start = 1'b1;
		end
	end

	ctm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign qmag = div_rsp.quo[17:0];
	assign qval = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
	assign qsat = (qval > 19'sd32767) ? 16'sh7fff
		: (qval < -19'sd32768) ? 16'sh8000 : qval[15:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q        <= '0;
			steps_q      <= '0;
			tone_setup_q <= '0;
			cad_q        <= '0;
			active_q     <= '0;
			pause_q      <= '0;
			rate_q       <= RATE_RESET;
			stereo_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AMP:    amp_q        <= cfg_data[14:0];
				REG_STEPS:  steps_q      <= cfg_data;
				REG_TONE:   tone_setup_q <= cfg_data[2:0];
				REG_CAD:    cad_q        <= cfg_data[3:0];
				REG_ACTIVE: active_q     <= cfg_data;
				REG_PAUSE:  pause_q      <= cfg_data;
				REG_RATE:   rate_q       <= cfg_data[17:0];
				REG_STEREO: stereo_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and cadence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q[0] <= '0;
			phase_q[1] <= '0;
			idx_q      <= '0;
			in_tone_q  <= 1'b1;
			remain_q   <= '0;
			started_q  <= 1'b0;
			ld_pause_q <= 1'b0;
			ld_last_q  <= 1'b0;
			chan_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						chan_q <= 1'b0;
						if (din.buffer_start || !started_q) begin
							phase_q[0] <= '0;
							phase_q[1] <= '0;
							idx_q      <= '0;
							in_tone_q  <= 1'b1;
							started_q  <= 1'b1;
							ld_pause_q <= 1'b0;
							ld_last_q  <= 1'b0;
							state_q    <= ST_LMUL;
						end else begin
							state_q <= ST_SIN;
						end
					end
				end
				ST_LMUL:   state_q <= ST_LSTART;
				ST_LSTART: state_q <= ST_LDIV;
				ST_LDIV: begin
					if (div_rsp.done) begin
						remain_q <= div_rsp.quo[REM_W-1:0];
						state_q  <= ld_last_q ? ST_FIN : ST_SIN;
					end
				end
				ST_SIN:  state_q <= mod2 ? ST_TMUL : ST_AMUL;
				ST_TMUL: state_q <= ST_AMUL;
				ST_AMUL: state_q <= ST_NUM;
				ST_NUM:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						if (!chan_q && stereo_q) begin
							chan_q  <= 1'b1;
							state_q <= ST_NUM;
						end else begin
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (in_tone_q) begin
						if (count != 2'd0) begin
							phase_q[0] <= phase_q[0] + steps_q[PHASE_BITS-1:0];
						end
						if (count == 2'd2) begin
							phase_q[1] <= phase_q[1] + steps_q[32 +: PHASE_BITS];
						end
						if (remain_q == '0) begin
							in_tone_q  <= 1'b0;
							ld_pause_q <= 1'b1;
							ld_last_q  <= 1'b1;
							state_q    <= ST_LMUL;
						end else begin
							remain_q <= remain_q - 1'b1;
							state_q  <= ST_FIN;
						end
					end else begin
						if (remain_q == '0) begin
							phase_q[0] <= '0;
							phase_q[1] <= '0;
							idx_q      <= idx_next;
							in_tone_q  <= 1'b1;
							ld_pause_q <= 1'b0;
							ld_last_q  <= 1'b1;
							state_q    <= ST_LMUL;
						end else begin
							remain_q <= remain_q - 1'b1;
							state_q  <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (dout.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && din.valid) begin
			inl_q <= din.left_sample;
			inr_q <= din.right_sample;
		end
		if (state_q == ST_SIN) begin
			s0_q      <= s0;
			s1_q      <= s1;
			tone_q    <= tone_d;
			tone_on_q <= in_tone_q;
		end
		if (state_q == ST_LMUL || state_q == ST_TMUL || state_q == ST_AMUL) begin
			mul_q <= prod[47:0];
		end
		if (state_q == ST_NUM) begin
			neg_q <= num[47];
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			if (chan_q) begin
				rout_q <= qsat;
			end else begin
				lout_q <= qsat;
				rout_q <= '0;
			end
		end
	end

	assign din.ready      = (state_q == ST_IDLE);
	assign dout.valid     = (state_q == ST_FIN);
	assign dout.left_out  = lout_q;
	assign dout.right_out = rout_q;
	assign dout.tone_on   = tone_on_q;

	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> !din.ready)
		else $error("item accepted while busy");

	a_mono_right: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !stereo_q |-> dout.right_out == 16'sd0)
		else $error("right sample not zero in mono");

	a_div_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_LDIV || state_q == ST_DIV))
		else $error("divider finished outside a divide step");

	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid |-> !din.ready)
		else $error("input open while result pending");

endmodule

@@ rtl/ctm_div.sv @@
// ----------------------------------------------------------------------------
// ctm_div
// Restoring divider, one quotient bit per cycle, 17 or 34 quotient bits.
// ----------------------------------------------------------------------------
module ctm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ctm_pkg::div_req_t  req,
	output ctm_pkg::div_rsp_t  rsp
);
	import ctm_pkg::*;

	logic             busy_q;
	logic [5:0]       cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] dvd_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.long_mode ? DIV_LONG_STEPS : DIV_SHORT_STEPS;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			quo_q <= '0;
			if (req.long_mode) begin
				rem_q <= {18'd0, req.num[NUM_W-1:34]};
				dvd_q <= {req.num[33:0], 14'd0};
			end else begin
				rem_q <= {1'b0, req.num[NUM_W-1:17]};
				dvd_q <= {req.num[16:0], 31'd0};
			end
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.quo  = quo_q;

endmodule
